// ===== hdl/rocr_pkg.sv =====
// Shared types and constants for the rate-of-change ratio core.
// Used by rocr_ctrl, rocr_dp and rate_of_change_ratio_core; no dependencies.
package rocr_pkg;

  // Delay line depth and derived widths
  localparam int MAX_LAG    = 64;
  localparam int SLOT_W     = $clog2(MAX_LAG);
  localparam int LAG_W      = $clog2(MAX_LAG + 1);
  localparam int CNT_W      = LAG_W;
  localparam int LAG_RESET  = 10;

  // Datapath widths
  localparam int DATA_W     = 32;
  localparam int Q_SHIFT    = 16;
  localparam int D_W        = DATA_W + 1;
  localparam int SCL_W      = 40;
  localparam int HI_W       = SCL_W - Q_SHIFT;
  localparam int HUNDRED    = 100;
  localparam int DIV_STEPS  = DATA_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_ROC     = 2'd0,
    MODE_ROCP    = 2'd1,
    MODE_ROCR    = 2'd2,
    MODE_ROCR100 = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_LAG  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCALE,
    S_NORM,
    S_DIV,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic scale;
    logic norm;
    logic step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;
    logic ovf;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/rocr_ctrl.sv =====
// Sequencer for the rate-of-change ratio core: one item at a time.
// Depends on rocr_pkg; drives rocr_dp through cmd_t, reads sts_t.
module rocr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rocr_pkg::sts_t sts,
  output rocr_pkg::cmd_t cmd
);
  import rocr_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = sts.skip ? S_DONE : S_SCALE;
      end
      S_SCALE: begin
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cnt_nxt   = '0;
        state_nxt = sts.ovf ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOAD:  cmd.load   = 1'b1;
      S_SCALE: cmd.scale  = 1'b1;
      S_NORM:  cmd.norm   = 1'b1;
      S_DIV:   cmd.step   = 1'b1;
      S_DONE:  cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/rocr_dp.sv =====
// Datapath: config registers, price delay line, numerator build,
// radix-2 divider with saturation, and the output register. Uses rocr_pkg.
module rocr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rocr_pkg::cmd_t                       cmd,
  output rocr_pkg::sts_t                       sts,
  input  logic signed [rocr_pkg::DATA_W-1:0]   in_price,
  input  logic                                 in_series_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rocr_pkg::DATA_W-1:0]   out_value,
  output logic                                 out_value_valid,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rocr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rocr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rocr_pkg::*;

  // Config
  mode_t             mode_r;
  logic [LAG_W-1:0]  lag_r;

  // Series state
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  seen_r;
  logic [DATA_W-1:0] anchor_r;
  logic [DATA_W-1:0] hist_mem [MAX_LAG];
  logic [DATA_W-1:0] rd_data_r;

  // Per-item registers
  logic signed [DATA_W-1:0] p_r;
  logic                     use_anchor_r;
  logic                     valid_r;
  logic                     skip_r;
  logic                     ovf_r;
  logic signed [DATA_W-1:0] q_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [SCL_W-1:0]  m_r;
  logic [DATA_W-1:0]        qmag_r;
  logic                     neg_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        quo_r;

  // Output register
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_value_r;
  logic                     out_vv_r;
  logic                     out_sat_r;

  // Accept-cycle signals
  logic [SLOT_W-1:0] slot_eff;
  logic [CNT_W-1:0]  seen_eff;
  logic [LAG_W-1:0]  eff_lag;
  logic [LAG_W-1:0]  slot_ext;
  logic [LAG_W-1:0]  idx_full;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] slot_inc;
  logic [CNT_W-1:0]  seen_inc;

  // Later-stage signals
  logic signed [DATA_W-1:0] q_sel;
  logic signed [D_W-1:0]    d_nxt;
  logic signed [SCL_W-1:0]  d_ext;
  logic signed [SCL_W-1:0]  m_nxt;
  logic [SCL_W-1:0]         mmag;
  logic [HI_W-1:0]          mhi;
  logic                     ovf;
  logic [DATA_W:0]          sh;
  logic [DATA_W:0]          sh_diff;
  logic                     ge;
  logic [DATA_W-1:0]        fin_value;
  logic                     fin_sat;

  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ROC;
      lag_r  <= LAG_W'(LAG_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= mode_t'(cfg_wdata[1:0]);
        REG_LAG:  lag_r  <= cfg_wdata[LAG_W-1:0];
        default:  ;
      endcase
    end
  end

  // Slot and count as seen by this item, read address of the lagged price
  always_comb begin
    slot_eff = in_series_start ? '0 : slot_r;
    seen_eff = in_series_start ? '0 : seen_r;
    eff_lag  = (lag_r > LAG_W'(MAX_LAG)) ? LAG_W'(MAX_LAG) : lag_r;
    slot_ext = LAG_W'(slot_eff);
    if (slot_ext >= eff_lag) idx_full = slot_ext - eff_lag;
    else                     idx_full = slot_ext + LAG_W'(MAX_LAG) - eff_lag;
    rd_idx   = idx_full[SLOT_W-1:0];
    slot_inc = (slot_eff == SLOT_W'(MAX_LAG - 1)) ? '0 : slot_eff + SLOT_W'(1);
    seen_inc = (seen_eff < CNT_W'(MAX_LAG)) ? seen_eff + CNT_W'(1) : seen_eff;
  end

  // Delay line: read of the old entry and write of the new price
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r        <= hist_mem[rd_idx];
      hist_mem[slot_eff] <= in_price;
    end
  end

  // Series bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      seen_r <= '0;
    end else if (cmd.accept) begin
      slot_r <= slot_inc;
      seen_r <= seen_inc;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r          <= in_price;
      use_anchor_r <= (eff_lag == '0);
      valid_r      <= (eff_lag == '0) || (seen_eff >= eff_lag);
      if (seen_eff == '0) anchor_r <= in_price;
    end
  end

  // Earlier price and mode-dependent numerator (difference or current price)
  always_comb begin
    q_sel = use_anchor_r ? signed'(anchor_r) : signed'(rd_data_r);
    case (mode_r) inside
      MODE_ROC, MODE_ROCP: d_nxt = D_W'(p_r) - D_W'(q_sel);
      default:             d_nxt = D_W'(p_r);
    endcase
  end

  assign sts.skip = !valid_r || (q_sel == '0);

  // Times hundred where the mode calls for it
  always_comb begin
    d_ext = SCL_W'(d_r);
    case (mode_r) inside
      MODE_ROC, MODE_ROCR100: m_nxt = d_ext * signed'(SCL_W'(HUNDRED));
      default:                m_nxt = d_ext;
    endcase
  end

  // Magnitude of the numerator and quotient range check
  always_comb begin
    mmag = m_r[SCL_W-1] ? SCL_W'(-m_r) : SCL_W'(m_r);
    mhi  = mmag[SCL_W-1:Q_SHIFT];
    ovf  = DATA_W'(mhi) >= qmag_r;
  end

  assign sts.ovf = ovf;

  // One restoring division step
  always_comb begin
    sh      = {rem_r, quo_r[DATA_W-1]};
    sh_diff = sh - {1'b0, qmag_r};
    ge      = sh >= {1'b0, qmag_r};
  end

  // Arithmetic pipeline and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r    <= q_sel;
      d_r    <= d_nxt;
      skip_r <= sts.skip;
    end
    if (cmd.scale) begin
      m_r    <= m_nxt;
      qmag_r <= q_r[DATA_W-1] ? DATA_W'(-q_r) : DATA_W'(q_r);
      neg_r  <= q_r[DATA_W-1];
    end
    if (cmd.norm) begin
      neg_r <= neg_r ^ m_r[SCL_W-1];
      ovf_r <= ovf;
      rem_r <= DATA_W'(mhi);
      quo_r <= {mmag[Q_SHIFT-1:0], {(DATA_W-Q_SHIFT){1'b0}}};
    end
    if (cmd.step) begin
      rem_r <= ge ? sh_diff[DATA_W-1:0] : sh[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
  end

  // Sign, saturation and special cases
  always_comb begin
    fin_value = '0;
    fin_sat   = 1'b0;
    if (skip_r) begin
      fin_value = '0;
    end else if (ovf_r) begin
      fin_value = neg_r ? VAL_MIN : VAL_MAX;
      fin_sat   = 1'b1;
    end else if (!neg_r) begin
      fin_value = quo_r[DATA_W-1] ? VAL_MAX : quo_r;
      fin_sat   = quo_r[DATA_W-1];
    end else if (quo_r > VAL_MIN) begin
      fin_value = VAL_MIN;
      fin_sat   = 1'b1;
    end else begin
      fin_value = DATA_W'(-quo_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r <= fin_value;
      out_vv_r    <= valid_r;
      out_sat_r   <= fin_sat;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_value       = signed'(out_value_r);
  assign out_value_valid = out_vv_r;
  assign out_saturated   = out_sat_r;

endmodule

// ===== hdl/rate_of_change_ratio_core.sv =====
// Rate-of-change ratio core (ROC / ROCP / ROCR / ROCR100 on Q16.16 prices).
// Each item is loaded, scaled, normalized and run through the 32-step radix-2
// divider (warm-up or zero earlier price skip to the result, overflow skips the
// divider); the next item is taken only after the result is registered.
// Reset (rst_n, synchronous, active low): mode 0, lag 10, new series, no
// pending result. Delay line entries are not cleared.
module rate_of_change_ratio_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rocr_pkg::DATA_W-1:0]   in_price,
  input  logic                                 in_series_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rocr_pkg::DATA_W-1:0]   out_value,
  output logic                                 out_value_valid,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rocr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rocr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rocr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rocr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rocr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_price        (in_price),
    .in_series_start (in_series_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule
